// File: rtl/p2g_pkg.sv
// p2g_pkg: types and constants for the pixel to ground plane projector
// no dependencies
package p2g_pkg;

  localparam int PIX_W   = 16;
  localparam int ROT_W   = 16;
  localparam int RAY_W   = 18;
  localparam int PRD_W   = 34;
  localparam int V_W     = 36;
  localparam int HD_W    = 17;
  localparam int NUM_W   = V_W + HD_W;
  localparam int N_W     = NUM_W + 2;
  localparam int D_W     = V_W + 1;
  localparam int QB      = 26;
  localparam int R_W     = 64;
  localparam int POS_W   = 24;
  localparam int SUM_W   = 28;
  localparam int CFG_W   = 48;
  localparam int CIDX_W  = 4;

  localparam logic signed [RAY_W-1:0] HALF_PIXEL = RAY_W'(8);
  localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(8388608);

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROT_X    = 4'd0,
    CFG_ROT_Y    = 4'd1,
    CFG_ROT_Z    = 4'd2,
    CFG_POS_X    = 4'd3,
    CFG_POS_Y    = 4'd4,
    CFG_CAM_H    = 4'd5,
    CFG_FOCAL    = 4'd6,
    CFG_OPT_CTR  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic signed [15:0]      object_height;
  } in_word_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [POS_W-1:0] ground_x;
    logic signed [POS_W-1:0] ground_y;
  } out_word_t;

  typedef struct packed {
    logic valid_res;
    logic neg_x;
    logic neg_y;
  } side_t;

  typedef struct packed {
    logic [CFG_W-1:0]        rot_x;
    logic [CFG_W-1:0]        rot_y;
    logic [CFG_W-1:0]        rot_z;
    logic [PIX_W-1:0]        focal;
    logic [31:0]             opt_ctr;
    logic signed [15:0]      cam_h;
  } rot_cfg_t;

endpackage

// File: rtl/p2g_ray_rotate.sv
// p2g_ray_rotate: camera ray forming, matrix products and row sums, two stages
// depends on p2g_pkg
module p2g_ray_rotate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  p2g_pkg::in_word_t               word_i,
  input  p2g_pkg::rot_cfg_t               cfg_i,
  output logic                            vld_o,
  output logic signed [p2g_pkg::V_W-1:0]  vx_o,
  output logic signed [p2g_pkg::V_W-1:0]  vy_o,
  output logic signed [p2g_pkg::V_W-1:0]  vz_o,
  output logic signed [p2g_pkg::HD_W-1:0] hd_o
);
  import p2g_pkg::*;

  logic signed [RAY_W-1:0] ray [3];
  logic [CFG_W-1:0]        rows [3];
  logic signed [PRD_W-1:0] prod_d [3][3];
  logic signed [PRD_W-1:0] prod_q [3][3];
  logic signed [HD_W-1:0]  hd1_q, hd2_q;
  logic signed [V_W-1:0]   v_q [3];
  logic                    vld1_q, vld2_q;

  assign rows[0] = cfg_i.rot_x;
  assign rows[1] = cfg_i.rot_y;
  assign rows[2] = cfg_i.rot_z;

  always_comb begin
    ray[0] = $signed({2'b00, cfg_i.focal});
    ray[1] = $signed({2'b00, cfg_i.opt_ctr[15:0]}) - HALF_PIXEL
             - $signed({2'b00, word_i.pixel_x});
    ray[2] = $signed({2'b00, cfg_i.opt_ctr[31:16]}) - HALF_PIXEL
             - $signed({2'b00, word_i.pixel_y});
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PRD_W'($signed(rows[r][16*c +: ROT_W])) * PRD_W'(ray[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      hd1_q  <= HD_W'(word_i.object_height) - HD_W'(cfg_i.cam_h);
      hd2_q  <= hd1_q;
      for (int r = 0; r < 3; r++) begin
        v_q[r] <= V_W'(prod_q[r][0]) + V_W'(prod_q[r][1]) + V_W'(prod_q[r][2]);
      end
    end
  end

  assign vld_o = vld2_q;
  assign vx_o  = v_q[0];
  assign vy_o  = v_q[1];
  assign vz_o  = v_q[2];
  assign hd_o  = hd2_q;

endmodule

// File: rtl/p2g_divider.sv
// p2g_divider: two lane restoring divider, one quotient bit per stage
// depends on p2g_pkg
module p2g_divider (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   vld_i,
  input  logic [1:0][p2g_pkg::N_W-1:0]           num_i,
  input  logic [p2g_pkg::D_W-1:0]                den_i,
  input  p2g_pkg::side_t                         side_i,
  output logic                                   vld_o,
  output logic [1:0][p2g_pkg::QB-1:0]            quo_o,
  output p2g_pkg::side_t                         side_o
);
  import p2g_pkg::*;

  logic [QB:0]       vld_q;
  logic [R_W-1:0]    rem_q [QB+1][2];
  logic [QB-1:0]     quo_q [QB+1][2];
  logic              ovf_q [QB+1][2];
  logic [D_W-1:0]    den_q [QB+1];
  side_t             side_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= R_W'(num_i[l]);
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= R_W'(num_i[l]) >= (R_W'(den_i) << QB);
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [R_W-1:0] sub [2];
    logic           ge  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sub[l] = rem_q[k][l] - (R_W'(den_q[k]) << B);
        ge[l]  = rem_q[k][l] >= (R_W'(den_q[k]) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
        for (int l = 0; l < 2; l++) begin
          rem_q[k+1][l] <= ge[l] ? sub[l] : rem_q[k][l];
          quo_q[k+1][l] <= quo_q[k][l] | (QB'(ge[l]) << B);
          ovf_q[k+1][l] <= ovf_q[k][l];
        end
      end
    end
  end

  assign vld_o    = vld_q[QB];
  assign side_o   = side_q[QB];
  assign quo_o[0] = ovf_q[QB][0] ? '1 : quo_q[QB][0];
  assign quo_o[1] = ovf_q[QB][1] ? '1 : quo_q[QB][1];

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni) !en_i |=> $stable(vld_q);
  endproperty
  a_hold: assert property (p_hold) else $error("divider valid bits moved while held");

  property p_shift;
    @(posedge clk_i) disable iff (!rst_ni) en_i && vld_q[QB-1] |=> vld_o;
  endproperty
  a_shift: assert property (p_shift) else $error("divider lost a word");

  property p_ovf_ones;
    @(posedge clk_i) disable iff (!rst_ni) vld_o && ovf_q[QB][0] |-> (&quo_o[0]);
  endproperty
  a_ovf_ones: assert property (p_ovf_ones) else $error("overflow not clamped");

endmodule

// File: rtl/pixel_to_ground_plane.sv
// pixel_to_ground_plane: top level, configuration registers, numerator stage,
// divider and saturating output stage; depends on p2g_pkg, p2g_ray_rotate, p2g_divider
//
// Projects one pixel per cycle onto the horizontal plane at the requested height.
// A word passes 32 register stages from acceptance to result: two for ray rotation,
// one for the numerator multiply, one for magnitude forming, 27 in the restoring
// divider (an input stage, then one quotient bit per stage), and one for the saturating
// add. The pipeline accepts a new word every cycle; while the output register holds a
// stalled result the whole pipeline halts. Configuration may be written only while idle.
module pixel_to_ground_plane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  p2g_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output p2g_pkg::out_word_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [p2g_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [p2g_pkg::CFG_W-1:0]     cfg_data_i
);
  import p2g_pkg::*;

  logic                    en;
  rot_cfg_t                rcfg_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;

  logic                    r_vld;
  logic signed [V_W-1:0]   vx, vy, vz;
  logic signed [HD_W-1:0]  hd;

  logic                    s3_vld_q;
  logic signed [NUM_W-1:0] num_x_q, num_y_q;
  logic signed [V_W-1:0]   vz3_q;
  logic                    vres3_q;

  logic                    s4_vld_q;
  logic [1:0][N_W-1:0]     n4_q;
  logic [D_W-1:0]          d4_q;
  side_t                   side4_q;

  logic                    d_vld;
  logic [1:0][QB-1:0]      quo;
  side_t                   d_side;

  logic signed [SUM_W-1:0] sx, sy;
  logic                    out_valid_q;
  out_word_t               out_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcfg_q  <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROT_X:   rcfg_q.rot_x   <= cfg_data_i;
        CFG_ROT_Y:   rcfg_q.rot_y   <= cfg_data_i;
        CFG_ROT_Z:   rcfg_q.rot_z   <= cfg_data_i;
        CFG_POS_X:   pos_x_q        <= cfg_data_i[POS_W-1:0];
        CFG_POS_Y:   pos_y_q        <= cfg_data_i[POS_W-1:0];
        CFG_CAM_H:   rcfg_q.cam_h   <= cfg_data_i[15:0];
        CFG_FOCAL:   rcfg_q.focal   <= cfg_data_i[PIX_W-1:0];
        CFG_OPT_CTR: rcfg_q.opt_ctr <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  p2g_ray_rotate u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .word_i (in_data_i),
    .cfg_i  (rcfg_q),
    .vld_o  (r_vld),
    .vx_o   (vx),
    .vy_o   (vy),
    .vz_o   (vz),
    .hd_o   (hd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= r_vld;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q <= NUM_W'(vx) * NUM_W'(hd);
      num_y_q <= NUM_W'(vy) * NUM_W'(hd);
      vz3_q   <= vz;
      vres3_q <= (vz != '0) && (hd != '0) && (vz[V_W-1] == hd[HD_W-1]);

      n4_q[0] <= (N_W'(num_x_q[NUM_W-1] ? -num_x_q : num_x_q) << 1)
                 + N_W'(vz3_q[V_W-1] ? -vz3_q : vz3_q);
      n4_q[1] <= (N_W'(num_y_q[NUM_W-1] ? -num_y_q : num_y_q) << 1)
                 + N_W'(vz3_q[V_W-1] ? -vz3_q : vz3_q);
      d4_q    <= D_W'(vz3_q[V_W-1] ? -vz3_q : vz3_q) << 1;
      side4_q.valid_res <= vres3_q;
      side4_q.neg_x     <= num_x_q[NUM_W-1] ^ vz3_q[V_W-1];
      side4_q.neg_y     <= num_y_q[NUM_W-1] ^ vz3_q[V_W-1];
    end
  end

  p2g_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .num_i  (n4_q),
    .den_i  (d4_q),
    .side_i (side4_q),
    .vld_o  (d_vld),
    .quo_o  (quo),
    .side_o (d_side)
  );

  always_comb begin
    sx = (d_side.neg_x ? -SUM_W'(quo[0]) : SUM_W'(quo[0])) + SUM_W'(pos_x_q);
    sy = (d_side.neg_y ? -SUM_W'(quo[1]) : SUM_W'(quo[1])) + SUM_W'(pos_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.valid_res <= d_side.valid_res;
      if (!d_side.valid_res) begin
        out_q.ground_x <= '0;
        out_q.ground_y <= '0;
      end else begin
        out_q.ground_x <= (sx > SAT_MAX) ? POS_W'(SAT_MAX) :
                          (sx < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(sx);
        out_q.ground_y <= (sy > SAT_MAX) ? POS_W'(SAT_MAX) :
                          (sy < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(sy);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  property p_miss_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_data_o.valid_res |-> out_data_o.ground_x == '0
                                              && out_data_o.ground_y == '0;
  endproperty
  a_miss_zero: assert property (p_miss_zero) else $error("miss word not zeroed");

  property p_deliver;
    @(posedge clk_i) disable iff (!rst_ni) en && d_vld |=> out_valid_o;
  endproperty
  a_deliver: assert property (p_deliver) else $error("result word lost");

  property p_s3;
    @(posedge clk_i) disable iff (!rst_ni) !en |=> $stable(s3_vld_q) && $stable(s4_vld_q);
  endproperty
  a_s3: assert property (p_s3) else $error("pipeline moved while held");

endmodule
